[sv/apsel_pkg.sv]
// apsel_pkg: sizes, operation codes, item types and address helper for the
// adaptive plane selector; no dependencies, imported by every module of the block
package apsel_pkg;

  localparam int PLANES    = 4;
  localparam int NODES     = 64;
  localparam int PLANE_W   = 2;
  localparam int NODE_W    = 6;
  localparam int OCC_DW    = 32;
  localparam int COST_W    = OCC_DW + 1;
  localparam int OCC_DEPTH = PLANES * NODES;
  localparam int OCC_AW    = $clog2(OCC_DEPTH);

  localparam logic [1:0] OP_WR_UP = 2'd0;
  localparam logic [1:0] OP_WR_DN = 2'd1;
  localparam logic [1:0] OP_ROUTE = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [NODE_W-1:0]  src_node;
    logic [NODE_W-1:0]  dest_node;
    logic [PLANE_W-1:0] plane_sel;
    logic [OCC_DW-1:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic [PLANE_W-1:0] chosen_plane;
    logic               is_local;
    logic [COST_W-1:0]  bottleneck_bytes;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [OCC_AW-1:0] addr;
    logic [OCC_DW-1:0] data;
  } occ_wr_t;

  typedef struct packed {
    logic              en;
    logic [OCC_AW-1:0] addr;
  } occ_rd_t;

  // entry plane*NODES + node
  function automatic logic [OCC_AW-1:0] occ_addr(logic [PLANE_W-1:0] plane,
                                                 logic [NODE_W-1:0] node);
    logic [OCC_AW-1:0] base;
    base = OCC_AW'(plane) * OCC_AW'(NODES);
    return base + OCC_AW'(node);
  endfunction

endpackage

[sv/apsel_occ_ram.sv]
// apsel_occ_ram: one occupancy memory, one write and one read port, registered read
// per-entry valid flops make unwritten entries read as zero; uses apsel_pkg
module apsel_occ_ram
  import apsel_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  occ_wr_t           wr,
  input  occ_rd_t           rd,
  output logic [OCC_DW-1:0] rd_data
);

  logic [OCC_DW-1:0]    occ_mem [OCC_DEPTH];
  logic [OCC_DEPTH-1:0] vld_r;
  logic [OCC_DW-1:0]    data_r;
  logic                 hit_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      occ_mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      data_r <= occ_mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        hit_r <= vld_r[rd.addr];
      end
    end
  end

  assign rd_data = hit_r ? data_r : '0;

endmodule

[sv/apsel_ctrl.sv]
// apsel_ctrl: item decode, per-plane read sequencer and least-bottleneck compare
// drives both occupancy memories; uses apsel_pkg
module apsel_ctrl
  import apsel_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output occ_wr_t           up_wr,
  output occ_wr_t           dn_wr,
  output occ_rd_t           up_rd,
  output occ_rd_t           dn_rd,
  input  logic [OCC_DW-1:0] up_data,
  input  logic [OCC_DW-1:0] dn_data,
  input  logic              slot_free,
  output logic              res_valid,
  output out_item_t         res_item
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic               accept;
  logic               upd_ok;
  logic               route_ok;
  logic [NODE_W:0]    node_sum;
  logic [PLANE_W-1:0] pref;
  logic               last_issue;

  logic [NODE_W-1:0]  src_r;
  logic [NODE_W-1:0]  dst_r;
  logic [OCC_DW-1:0]  chunk_r;
  logic [PLANE_W-1:0] cur_r;
  logic [PLANE_W-1:0] cnt_r;

  logic               rd_pend_r;
  logic               rd_first_r;
  logic [PLANE_W-1:0] rd_plane_r;

  logic               cost_vld_r;
  logic               cost_first_r;
  logic [PLANE_W-1:0] cost_plane_r;
  logic [COST_W-1:0]  cost_r;
  logic [OCC_DW-1:0]  worst;

  logic [PLANE_W-1:0] best_plane_r;
  logic [COST_W-1:0]  best_cost_r;
  logic               local_r;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign upd_ok   = (int'(in_item.plane_sel) < PLANES) && (int'(in_item.src_node) < NODES);
  assign route_ok = (int'(in_item.src_node) < NODES) && (int'(in_item.dest_node) < NODES);

  // preferred plane, PLANES is a power of two so this is a mask
  assign node_sum = (NODE_W + 1)'(in_item.src_node) + (NODE_W + 1)'(in_item.dest_node);
  assign pref     = PLANE_W'(node_sum % (NODE_W + 1)'(PLANES));

  assign last_issue = (cnt_r == PLANE_W'(PLANES - 1));

  // updates write on the accept edge, routes only read afterwards
  always_comb begin
    up_wr.en   = accept && (in_item.operation == OP_WR_UP) && upd_ok;
    up_wr.addr = occ_addr(in_item.plane_sel, in_item.src_node);
    up_wr.data = in_item.byte_count;
    dn_wr.en   = accept && (in_item.operation == OP_WR_DN) && upd_ok;
    dn_wr.addr = up_wr.addr;
    dn_wr.data = in_item.byte_count;
    up_rd.en   = (state_r == S_ISSUE);
    up_rd.addr = occ_addr(cur_r, src_r);
    dn_rd.en   = (state_r == S_ISSUE);
    dn_rd.addr = occ_addr(cur_r, dst_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_item.operation == OP_ROUTE) && route_ok) begin
          state_nxt = (in_item.src_node == in_item.dest_node) ? S_DONE : S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_pend_r && !cost_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_pend_r  <= 1'b0;
      cost_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_pend_r  <= (state_r == S_ISSUE);
      cost_vld_r <= rd_pend_r;
    end
  end

  assign worst = (up_data > dn_data) ? up_data : dn_data;

  always_ff @(posedge clk) begin
    if (accept) begin
      src_r   <= in_item.src_node;
      dst_r   <= in_item.dest_node;
      chunk_r <= in_item.byte_count;
      cur_r   <= pref;
      cnt_r   <= '0;
      local_r <= (in_item.src_node == in_item.dest_node);
      best_plane_r <= '0;
      best_cost_r  <= '0;
    end else if (state_r == S_ISSUE) begin
      cur_r <= (cur_r == PLANE_W'(PLANES - 1)) ? '0 : cur_r + 1'b1;
      cnt_r <= cnt_r + 1'b1;
    end
    // stage 1: read data returns
    rd_first_r <= (state_r == S_ISSUE) && (cnt_r == '0);
    rd_plane_r <= cur_r;
    // stage 2: bottleneck of that plane
    cost_first_r <= rd_first_r;
    cost_plane_r <= rd_plane_r;
    cost_r       <= COST_W'(worst) + COST_W'(chunk_r);
    // stage 3: keep the strict minimum, earlier plane in rotation wins a tie
    if (cost_vld_r && (cost_first_r || (cost_r < best_cost_r))) begin
      best_plane_r <= cost_plane_r;
      best_cost_r  <= cost_r;
    end
  end

  assign res_valid                 = (state_r == S_DONE);
  assign res_item.chosen_plane     = best_plane_r;
  assign res_item.is_local         = local_r;
  assign res_item.bottleneck_bytes = best_cost_r;

  // no memory write while a route is in flight
  a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (!up_wr.en && !dn_wr.en))
    else $error("occupancy write during route");

  // compare stage only fed by a read pending in the cycle before
  a_cost_from_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cost_vld_r |-> $past(rd_pend_r))
    else $error("cost without read");

  // result shown only once the compare pipeline is empty
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (!rd_pend_r && !cost_vld_r))
    else $error("result before compare drained");

  // reads only issued by the sequencer
  a_rd_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == S_ISSUE))
    else $error("read pending without issue");

endmodule

[sv/adaptive_plane_selector_unit.sv]
// adaptive_plane_selector_unit: top level, two occupancy memories, sequencer and
// output register; depends on apsel_pkg, apsel_occ_ram, apsel_ctrl
//
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_ready  | in_item_t  (operation, nodes, plane, bytes)
// out_     | output    | out_valid/out_ready| out_item_t (plane, local flag, bottleneck)
//
// an update item is written into memory on its accept edge
// a local route goes from accept straight to the done state and on to the output
// register; a remote route runs accept, one read per plane from each memory, a drain
// of the max/add and compare stages, then the done state
// the per-plane read of the two single-read-port memories sets a remote route's length
// reset clears the state machine and the per-entry valid flops, so all counts read zero
// a result waiting in the output register does not stop the next item being accepted;
// a finished route holds in its done state while the output register is full
module adaptive_plane_selector_unit
  import apsel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  occ_wr_t           up_wr;
  occ_wr_t           dn_wr;
  occ_rd_t           up_rd;
  occ_rd_t           dn_rd;
  logic [OCC_DW-1:0] up_data;
  logic [OCC_DW-1:0] dn_data;
  logic              slot_free;
  logic              res_valid;
  out_item_t         res_item;

  logic              out_valid_r;
  out_item_t         out_item_r;

  // uplink counts, entry plane*NODES + source node
  apsel_occ_ram u_up_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (up_wr),
    .rd      (up_rd),
    .rd_data (up_data)
  );

  // downlink counts, entry plane*NODES + destination node
  apsel_occ_ram u_dn_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (dn_wr),
    .rd      (dn_rd),
    .rd_data (dn_data)
  );

  apsel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .up_wr     (up_wr),
    .dn_wr     (dn_wr),
    .up_rd     (up_rd),
    .dn_rd     (dn_rd),
    .up_data   (up_data),
    .dn_data   (dn_data),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  // output register is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res_valid;
    end
  end

  // payload register, loaded only with a fresh result
  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[sim/apsel_route_checker.sv]
// apsel_route_checker: watches both channels of the adaptive plane selector,
// keeps its own copy of the link counts and checks every route result in order
// depends on apsel_pkg for the item types, sizes and operation codes
`timescale 1ns / 100ps

module apsel_route_checker
  import apsel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending_count
);

  localparam int REPORT_MAX = 10;

  logic [OCC_DW-1:0] up_occ [OCC_DEPTH];
  logic [OCC_DW-1:0] dn_occ [OCC_DEPTH];
  out_item_t         expected_routes[$];
  int                mismatch_count = 0;

  // least bottleneck over all planes, scanned from the preferred plane on
  function automatic out_item_t route_result(in_item_t it);
    out_item_t         res;
    int                pref;
    int                p;
    logic [OCC_DW-1:0] up;
    logic [OCC_DW-1:0] dn;
    logic [OCC_DW-1:0] worst;
    logic [COST_W-1:0] cost;
    res = '0;
    if (it.src_node == it.dest_node) begin
      res.is_local = 1'b1;
      return res;
    end
    pref = (int'(it.src_node) + int'(it.dest_node)) % PLANES;
    for (int k = 0; k < PLANES; k++) begin
      p     = (pref + k) % PLANES;
      up    = up_occ[p * NODES + int'(it.src_node)];
      dn    = dn_occ[p * NODES + int'(it.dest_node)];
      worst = (up > dn) ? up : dn;
      cost  = {1'b0, worst} + {1'b0, it.byte_count};
      // strict less keeps the earlier plane of the rotation on a tie
      if (k == 0 || cost < res.bottleneck_bytes) begin
        res.chosen_plane     = PLANE_W'(p);
        res.bottleneck_bytes = cost;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      expected_routes.delete();
      for (int i = 0; i < OCC_DEPTH; i++) begin
        up_occ[i] = '0;
        dn_occ[i] = '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (expected_routes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected result: plane %0d local %0b bytes %h",
                     out_item.chosen_plane, out_item.is_local, out_item.bottleneck_bytes);
        end else begin
          want = expected_routes.pop_front();
          if (want.chosen_plane !== out_item.chosen_plane ||
              want.is_local !== out_item.is_local ||
              want.bottleneck_bytes !== out_item.bottleneck_bytes) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("route mismatch: expected %0d/%0b/%h got %0d/%0b/%h",
                       want.chosen_plane, want.is_local, want.bottleneck_bytes,
                       out_item.chosen_plane, out_item.is_local, out_item.bottleneck_bytes);
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_item.operation)
          OP_WR_UP: begin
            if (in_item.plane_sel < PLANES && in_item.src_node < NODES)
              up_occ[int'(in_item.plane_sel) * NODES + int'(in_item.src_node)] =
                in_item.byte_count;
          end
          OP_WR_DN: begin
            if (in_item.plane_sel < PLANES && in_item.src_node < NODES)
              dn_occ[int'(in_item.plane_sel) * NODES + int'(in_item.src_node)] =
                in_item.byte_count;
          end
          OP_ROUTE: begin
            if (in_item.src_node < NODES && in_item.dest_node < NODES)
              expected_routes.push_back(route_result(in_item));
          end
          default: begin
          end
        endcase
      end
    end
    fail_count    <= mismatch_count;
    pending_count <= expected_routes.size();
  end

endmodule

[sim/testbench.sv]
// testbench: stimulus and verdict for adaptive_plane_selector_unit, with
// apsel_route_checker beside the block; depends on apsel_pkg and both modules
`timescale 1ns / 100ps

module testbench;
  import apsel_pkg::*;

  // operation code the block must drop without a result
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int CALM_FIRST   = 100;
  localparam int CALM_LAST    = 160;
  localparam int DRAIN_AT     = 200;
  localparam int HOLD_AT      = 250;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // calm: no idling on either side; hold_go: starts the one long receiver hold-off
  logic      calm;
  logic      hold_go;
  int        hold_cnt = 0;
  int        cycle_count = 0;
  int        fail_count;
  int        pending_count;

  always #5 clk = ~clk;

  adaptive_plane_selector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  apsel_route_checker route_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // watchdog: a run that hangs is a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // receiver: one long hold-off counted here, otherwise about 10% stall, none while calm
  always @(posedge clk) begin
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 10);
    end
  end

  function automatic in_item_t make_item(logic [1:0] op, int src, int dst, int plane,
                                         logic [OCC_DW-1:0] bytes);
    in_item_t it;
    it.operation  = op;
    it.src_node   = NODE_W'(src);
    it.dest_node  = NODE_W'(dst);
    it.plane_sel  = PLANE_W'(plane);
    it.byte_count = bytes;
    return it;
  endfunction

  // nodes mostly from a small group so updates and routes hit the same counts
  function automatic int pick_node();
    if ($urandom_range(0, 99) < 70)
      return $urandom_range(0, 7);
    return $urandom_range(0, NODES - 1);
  endfunction

  // byte counts: ties from small values, the extremes, mid-range values and full-width noise
  function automatic logic [OCC_DW-1:0] pick_bytes();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) return OCC_DW'($urandom_range(0, 15));
    if (r < 75) return OCC_DW'($urandom_range(0, 4096));
    return $urandom;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    int       src;
    int       dst;
    r   = $urandom_range(0, 99);
    src = pick_node();
    dst = ($urandom_range(0, 9) == 0) ? src : pick_node();
    if (r < 5)
      it = make_item(OP_UNUSED, src, dst, $urandom_range(0, 3), $urandom);
    else if (r < 28)
      it = make_item(OP_WR_UP, src, dst, $urandom_range(0, PLANES - 1), pick_bytes());
    else if (r < 50)
      it = make_item(OP_WR_DN, src, dst, $urandom_range(0, PLANES - 1), pick_bytes());
    else
      it = make_item(OP_ROUTE, src, dst, $urandom_range(0, 3), pick_bytes());
    return it;
  endfunction

  // offer one item, with a random gap first unless calm, and wait for its accept
  task automatic send_item(in_item_t it);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering until every route result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int       sent;
    in_item_t it;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    calm     = 1'b0;
    hold_go  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all counts zero, so the preferred plane wins with the chunk alone
    send_item(make_item(OP_ROUTE, 0, 1, 0, 32'd1));
    // local routes, the second with the largest chunk
    send_item(make_item(OP_ROUTE, 5, 5, 2, 32'd100));
    send_item(make_item(OP_ROUTE, 63, 63, 3, '1));
    // unused operation with every bit set
    send_item(make_item(OP_UNUSED, 63, 63, 3, '1));
    // zero chunk
    send_item(make_item(OP_ROUTE, 2, 7, 1, '0));
    // full counts on some planes push the winner away from the preferred plane
    send_item(make_item(OP_WR_UP, 63, 0, 0, '1));
    send_item(make_item(OP_WR_DN, 0, 0, 3, '1));
    send_item(make_item(OP_ROUTE, 63, 0, 0, '1));
    // every plane full: the 33-bit sum reaches its largest possible value
    send_item(make_item(OP_WR_UP, 63, 0, 1, '1));
    send_item(make_item(OP_WR_UP, 63, 0, 2, '1));
    send_item(make_item(OP_ROUTE, 63, 0, 0, '1));
    // clearing one count opens that plane again
    send_item(make_item(OP_WR_UP, 63, 0, 2, '0));
    send_item(make_item(OP_ROUTE, 63, 0, 2, '0));
    // downlink larger than uplink, and a strict winner after the preferred plane
    send_item(make_item(OP_WR_DN, 10, 0, 1, 32'd500));
    send_item(make_item(OP_WR_UP, 9, 0, 1, 32'd100));
    send_item(make_item(OP_ROUTE, 9, 10, 0, 32'd7));
    send_item(make_item(OP_WR_UP, 9, 0, 3, 32'd50));
    send_item(make_item(OP_ROUTE, 9, 10, 0, 32'd7));
    send_item(make_item(OP_ROUTE, 10, 9, 3, 32'hFFFF_FFF0));
    wait_for_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == CALM_FIRST) calm <= 1'b1;
      if (sent == CALM_LAST) calm <= 1'b0;
      if (sent == HOLD_AT) hold_go <= 1'b1;
      if (sent == DRAIN_AT || $urandom_range(0, 199) == 0) wait_for_results();
      it = random_item();
      send_item(it);
      if (it.operation != OP_UNUSED) sent++;
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
